@@ src/assert_macros.svh @@
// Concurrent check macros; they compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLN_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");
`define PLN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`else
`define PLN_ASSERT(lbl, clk, rstn, prop)
`define PLN_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ src/pln_pkg.sv @@
package pln_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int LEN_REGS   = 4;
    localparam int INDEX_BITS = 25;
    localparam int X_BITS     = INDEX_BITS - 1;
    localparam int LEN_BITS   = 7;
    localparam int PAIR_BITS  = 2 * LEN_BITS - 1;
    localparam int DIM_BITS   = 3;
    localparam int AXIS_BITS  = 2;

    localparam int MOD_STEPS  = 4;
    localparam int MOD_STAGES = (X_BITS + MOD_STEPS - 1) / MOD_STEPS;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_COUNT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEN_DIM0  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEN_DIM1  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEN_DIM2  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEN_DIM3  = 3'd4;

    localparam logic [LEN_BITS-1:0] LEN_MAX   = 7'd64;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd4;
    localparam logic [DIM_BITS-1:0] DIM_RESET = 3'd4;
    localparam logic [DIM_BITS-1:0] DIM_CAP   =
        DIM_BITS'((MAX_DIMS < LEN_REGS) ? MAX_DIMS : LEN_REGS);

    typedef struct packed {
        logic [DIM_BITS-1:0]                dims;
        logic [LEN_REGS-1:0][LEN_BITS-1:0]  len;
    } cfg_t;

    typedef struct packed {
        logic                   backward;
        logic [INDEX_BITS-1:0]  site;
        logic                   axis_bad;
        logic [INDEX_BITS-1:0]  size;
        logic [INDEX_BITS-1:0]  stride;
        logic [INDEX_BITS-1:0]  span;
        logic [INDEX_BITS-1:0]  jump;
        logic [INDEX_BITS-1:0]  rem;
        logic [X_BITS-1:0]      x;
    } item_t;

    function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] v);
        logic [LEN_BITS-1:0] r;
        priority if (v == '0)
            r = LEN_BITS'(1);
        else if (v > LEN_MAX)
            r = LEN_MAX;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [DIM_BITS-1:0] eff_dims(input logic [DIM_BITS-1:0] n);
        logic [DIM_BITS-1:0] r;
        priority if (n == '0)
            r = DIM_BITS'(1);
        else if (n > DIM_CAP)
            r = DIM_CAP;
        else
            r = n;
        return r;
    endfunction

endpackage

@@ src/pln_if.sv @@
interface pln_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [pln_pkg::INDEX_BITS-1:0]   site_index;
    logic [pln_pkg::AXIS_BITS-1:0]    axis;

    modport source (output valid, req_type, site_index, axis, input ready);
    modport sink   (input valid, req_type, site_index, axis, output ready);
endinterface

interface pln_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [pln_pkg::INDEX_BITS-1:0]   neighbor_index;
    logic                             bad_request;

    modport source (output valid, neighbor_index, bad_request, input ready);
    modport sink   (input valid, neighbor_index, bad_request, output ready);
endinterface

interface pln_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [pln_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [pln_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/pln_geom.sv @@
module pln_geom (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic                                in_backward,
    input  logic [pln_pkg::INDEX_BITS-1:0]      in_site,
    input  logic [pln_pkg::AXIS_BITS-1:0]       in_axis,
    input  pln_pkg::cfg_t                       cfg,
    output logic                                out_valid,
    output pln_pkg::item_t                      out_item
);

    localparam int SET_SIZE   = 0;
    localparam int SET_STRIDE = 1;
    localparam int SET_SPAN   = 2;
    localparam int SET_JUMP   = 3;
    localparam int SETS       = 4;

    logic [pln_pkg::LEN_BITS-1:0]   fac [SETS][pln_pkg::LEN_REGS];
    logic [pln_pkg::PAIR_BITS-1:0]  pair_next [SETS][2];
    logic [pln_pkg::PAIR_BITS-1:0]  pair_reg  [SETS][2];
    logic                           axis_bad_next;

    logic                           v1_reg;
    logic                           backward1_reg;
    logic [pln_pkg::INDEX_BITS-1:0] site1_reg;
    logic                           axis_bad1_reg;

    logic                           v2_reg;
    pln_pkg::item_t                 item2_reg;
    pln_pkg::item_t                 item2_next;

    // Per-axis factors; an axis outside a set contributes a one.
    always_comb
    begin
        for (int k = 0; k < pln_pkg::LEN_REGS; k++)
        begin
            fac[SET_SIZE][k]   = (pln_pkg::DIM_BITS'(k) < cfg.dims) ? cfg.len[k]
                                                                    : pln_pkg::LEN_BITS'(1);
            fac[SET_STRIDE][k] = (pln_pkg::AXIS_BITS'(k) < in_axis) ? cfg.len[k]
                                                                    : pln_pkg::LEN_BITS'(1);
            fac[SET_SPAN][k]   = (pln_pkg::AXIS_BITS'(k) <= in_axis) ? cfg.len[k]
                                                                     : pln_pkg::LEN_BITS'(1);
            if (pln_pkg::AXIS_BITS'(k) < in_axis)
                fac[SET_JUMP][k] = cfg.len[k];
            else if (pln_pkg::AXIS_BITS'(k) == in_axis)
                fac[SET_JUMP][k] = cfg.len[k] - pln_pkg::LEN_BITS'(1);
            else
                fac[SET_JUMP][k] = pln_pkg::LEN_BITS'(1);
        end
        for (int s = 0; s < SETS; s++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                pair_next[s][j] = pln_pkg::PAIR_BITS'(fac[s][2*j])
                                * pln_pkg::PAIR_BITS'(fac[s][2*j+1]);
            end
        end
        axis_bad_next = pln_pkg::DIM_BITS'(in_axis) >= cfg.dims;
    end

    always_comb
    begin
        item2_next.backward = backward1_reg;
        item2_next.site     = site1_reg;
        item2_next.axis_bad = axis_bad1_reg;
        item2_next.size     = pln_pkg::INDEX_BITS'(pair_reg[SET_SIZE][0])
                            * pln_pkg::INDEX_BITS'(pair_reg[SET_SIZE][1]);
        item2_next.stride   = pln_pkg::INDEX_BITS'(pair_reg[SET_STRIDE][0])
                            * pln_pkg::INDEX_BITS'(pair_reg[SET_STRIDE][1]);
        item2_next.span     = pln_pkg::INDEX_BITS'(pair_reg[SET_SPAN][0])
                            * pln_pkg::INDEX_BITS'(pair_reg[SET_SPAN][1]);
        item2_next.jump     = pln_pkg::INDEX_BITS'(pair_reg[SET_JUMP][0])
                            * pln_pkg::INDEX_BITS'(pair_reg[SET_JUMP][1]);
        item2_next.rem      = '0;
        item2_next.x        = pln_pkg::X_BITS'(site1_reg - pln_pkg::INDEX_BITS'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            backward1_reg <= in_backward;
            site1_reg     <= in_site;
            axis_bad1_reg <= axis_bad_next;
            pair_reg      <= pair_next;
            item2_reg     <= item2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;

endmodule

@@ src/pln_mod_stage.sv @@
module pln_mod_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  pln_pkg::item_t  in_item,
    output logic            out_valid,
    output pln_pkg::item_t  out_item
);

    logic           valid_reg;
    pln_pkg::item_t item_reg;
    pln_pkg::item_t item_next;

    // Shift in the next dividend bits, subtract the span where it fits.
    always_comb
    begin
        item_next = in_item;
        for (int i = 0; i < pln_pkg::MOD_STEPS; i++)
        begin
            item_next.rem = {item_next.rem[pln_pkg::INDEX_BITS-2:0],
                             item_next.x[pln_pkg::X_BITS-1]};
            item_next.x   = {item_next.x[pln_pkg::X_BITS-2:0], 1'b0};
            if (item_next.rem >= item_next.span)
                item_next.rem = item_next.rem - item_next.span;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ src/pln_resolve.sv @@
module pln_resolve (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_valid,
    input  pln_pkg::item_t                  in_item,
    output logic                            out_valid,
    output logic [pln_pkg::INDEX_BITS-1:0]  out_index,
    output logic                            out_bad
);

    logic                           valid_reg;
    logic [pln_pkg::INDEX_BITS-1:0] index_reg;
    logic                           bad_reg;
    logic [pln_pkg::INDEX_BITS-1:0] index_next;
    logic                           bad_next;
    logic                           wrap;
    logic [pln_pkg::INDEX_BITS-1:0] site_fwd;
    logic [pln_pkg::INDEX_BITS-1:0] site_back;
    logic [pln_pkg::INDEX_BITS-1:0] site_up;
    logic [pln_pkg::INDEX_BITS-1:0] site_down;

    always_comb
    begin
        bad_next  = (in_item.site == '0) || (in_item.site > in_item.size)
                  || in_item.axis_bad;
        site_fwd  = in_item.site + in_item.stride;
        site_back = in_item.site - in_item.stride;
        site_up   = in_item.site + in_item.jump;
        site_down = in_item.site - in_item.jump;
        // Wrap at the far end going forward, at coordinate zero going backward.
        if (in_item.backward)
        begin
            wrap       = in_item.rem < in_item.stride;
            index_next = wrap ? site_up : site_back;
        end
        else
        begin
            wrap       = in_item.rem >= in_item.jump;
            index_next = wrap ? site_down : site_fwd;
        end
        if (bad_next)
            index_next = in_item.site;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            index_reg <= index_next;
            bad_reg   <= bad_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_bad   = bad_reg;

endmodule

@@ src/periodic_lattice_neighbor_index.sv @@
// Periodic lattice neighbor index: for a one-based site index on a lattice of
// up to four dimensions (axis 0 varies fastest), returns the site one step
// forward or backward along the requested axis with periodic wrap-around.
// Requests with an index outside 1..lattice size or an axis at or beyond the
// dimension count come back with bad_request set and the index echoed.
// Throughput is one transaction per clock while the output is not stalled. The
// pipeline is made of two multiplier stages that form size and strides from
// the lengths, six stages of the bit-serial remainder (four bits per stage),
// and the output register.
// Lengths and dimension count are written on the cfg port (index 0 is the
// dimension count, 1..4 the lengths) and take effect for the next request;
// write them only while no request is in flight.
`include "assert_macros.svh"

module periodic_lattice_neighbor_index (
    input  logic          clk,
    input  logic          rst_n,
    pln_cfg_if.sink       cfg,
    pln_req_if.sink       req,
    pln_rsp_if.source     rsp
);

    logic [pln_pkg::DIM_BITS-1:0]   dim_count_reg;
    logic [pln_pkg::LEN_BITS-1:0]   len_reg [pln_pkg::LEN_REGS];
    pln_pkg::cfg_t                  cfg_eff;

    logic                           adv;
    logic                           geom_valid;
    pln_pkg::item_t                 geom_item;
    logic                           mod_valid [pln_pkg::MOD_STAGES+1];
    pln_pkg::item_t                 mod_item  [pln_pkg::MOD_STAGES+1];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= pln_pkg::DIM_RESET;
            for (int k = 0; k < pln_pkg::LEN_REGS; k++)
                len_reg[k] <= pln_pkg::LEN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                pln_pkg::REG_DIM_COUNT: dim_count_reg <= pln_pkg::DIM_BITS'(cfg.data);
                pln_pkg::REG_LEN_DIM0:  len_reg[0]    <= cfg.data;
                pln_pkg::REG_LEN_DIM1:  len_reg[1]    <= cfg.data;
                pln_pkg::REG_LEN_DIM2:  len_reg[2]    <= cfg.data;
                pln_pkg::REG_LEN_DIM3:  len_reg[3]    <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg_eff.dims = pln_pkg::eff_dims(dim_count_reg);
        for (int k = 0; k < pln_pkg::LEN_REGS; k++)
            cfg_eff.len[k] = pln_pkg::eff_len(len_reg[k]);
    end

    // Whole pipe moves together; hold everything while the output is stalled.
    assign adv       = !rsp.valid || rsp.ready;
    assign req.ready = adv;

    pln_geom u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (req.valid),
        .in_backward (req.req_type),
        .in_site     (req.site_index),
        .in_axis     (req.axis),
        .cfg         (cfg_eff),
        .out_valid   (geom_valid),
        .out_item    (geom_item)
    );

    assign mod_valid[0] = geom_valid;
    assign mod_item[0]  = geom_item;

    for (genvar g = 0; g < pln_pkg::MOD_STAGES; g++)
    begin : g_mod
        pln_mod_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (mod_valid[g]),
            .in_item   (mod_item[g]),
            .out_valid (mod_valid[g+1]),
            .out_item  (mod_item[g+1])
        );
    end

    pln_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mod_valid[pln_pkg::MOD_STAGES]),
        .in_item   (mod_item[pln_pkg::MOD_STAGES]),
        .out_valid (rsp.valid),
        .out_index (rsp.neighbor_index),
        .out_bad   (rsp.bad_request)
    );

    `PLN_ASSERT_IMP(a_rem_below_span, clk, rst_n, mod_valid[pln_pkg::MOD_STAGES], mod_item[pln_pkg::MOD_STAGES].rem < mod_item[pln_pkg::MOD_STAGES].span)
    `PLN_ASSERT_IMP(a_good_index_nonzero, clk, rst_n, rsp.valid && !rsp.bad_request, rsp.neighbor_index != '0)
    `PLN_ASSERT(a_accept_reaches_geom, clk, rst_n, (req.valid && req.ready) ##1 adv |=> geom_valid)

endmodule

@@ tb/tb_top.sv @@
module tb_top;

    localparam int NUM_PHASES      = 11;
    localparam int ITEMS_PER_PHASE = 166;
    localparam int SETTLE_CYCLES   = 12;
    localparam int STALL_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [pln_pkg::INDEX_BITS-1:0] nb_index;
        logic                           bad;
    } neighbor_t;

    class neighbor_scoreboard;
        logic [pln_pkg::DIM_BITS-1:0] dim_reg;
        logic [pln_pkg::LEN_BITS-1:0] len_reg [pln_pkg::LEN_REGS];
        neighbor_t                    expected_q [$];
        int                           errors;

        function new();
            dim_reg = pln_pkg::DIM_RESET;
            foreach (len_reg[k])
                len_reg[k] = pln_pkg::LEN_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [pln_pkg::CFG_INDEX_BITS-1:0] idx,
                                logic [pln_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                pln_pkg::REG_DIM_COUNT: dim_reg = data[pln_pkg::DIM_BITS-1:0];
                pln_pkg::REG_LEN_DIM0:  len_reg[0] = data;
                pln_pkg::REG_LEN_DIM1:  len_reg[1] = data;
                pln_pkg::REG_LEN_DIM2:  len_reg[2] = data;
                pln_pkg::REG_LEN_DIM3:  len_reg[3] = data;
                default: ;
            endcase
        endfunction

        function int dims_in_use();
            int n;
            int cap;
            cap = (pln_pkg::MAX_DIMS < pln_pkg::LEN_REGS) ? pln_pkg::MAX_DIMS
                                                          : pln_pkg::LEN_REGS;
            n = dim_reg;
            if (n == 0)
                n = 1;
            if (n > cap)
                n = cap;
            return n;
        endfunction

        // Zero reads as one, anything past the maximum extent clamps to it.
        function longint unsigned axis_len(int k);
            if (len_reg[k] == 0)
                return 1;
            if (len_reg[k] > pln_pkg::LEN_MAX)
                return pln_pkg::LEN_MAX;
            return len_reg[k];
        endfunction

        function longint unsigned axis_stride(int a);
            longint unsigned s;
            s = 1;
            for (int k = 0; k < a; k++)
                s = s * axis_len(k);
            return s;
        endfunction

        function longint unsigned site_total();
            return axis_stride(dims_in_use());
        endfunction

        function neighbor_t step_site(logic bkw, logic [pln_pkg::INDEX_BITS-1:0] site,
                                      logic [pln_pkg::AXIS_BITS-1:0] ax);
            neighbor_t       r;
            longint unsigned s;
            longint unsigned stride;
            longint unsigned len;
            longint unsigned coord;
            longint unsigned res;
            s = site;
            r.nb_index = site;
            r.bad = 1'b1;
            if (s == 0 || s > site_total() || int'(ax) >= dims_in_use())
                return r;
            stride = axis_stride(ax);
            len = axis_len(ax);
            coord = ((s - 1) % (stride * len)) / stride;
            // Wrap at the far end going forward, at coordinate zero going back.
            if (!bkw)
                res = (coord == len - 1) ? s - (len - 1) * stride : s + stride;
            else
                res = (coord == 0) ? s + (len - 1) * stride : s - stride;
            r.nb_index = res[pln_pkg::INDEX_BITS-1:0];
            r.bad = 1'b0;
            return r;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void note_request(logic bkw, logic [pln_pkg::INDEX_BITS-1:0] site,
                                   logic [pln_pkg::AXIS_BITS-1:0] ax);
            expected_q.insert(expected_q.size(), step_site(bkw, site, ax));
        endfunction

        function void check_result(logic [pln_pkg::INDEX_BITS-1:0] got_index,
                                   logic got_bad);
            neighbor_t exp_r;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("unexpected result: index %0d bad %0b", got_index, got_bad));
                return;
            end
            exp_r = expected_q.pop_front();
            if (got_index !== exp_r.nb_index)
                flag($sformatf("neighbor_index mismatch: expected %0d, got %0d",
                               exp_r.nb_index, got_index));
            if (got_bad !== exp_r.bad)
                flag($sformatf("bad_request mismatch: expected %0b, got %0b",
                               exp_r.bad, got_bad));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int failures();
            return errors + expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;

    neighbor_scoreboard sb = new();

    pln_req_if req_ch ();
    pln_rsp_if rsp_ch ();
    pln_cfg_if cfg_ch ();

    periodic_lattice_neighbor_index u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // dim_count, len_dim0..len_dim3; row zero holds the reset values
    int unsigned phase_tab [NUM_PHASES][5] = '{
        '{4,   4,   4,  4, 4},
        '{4,  64,  64, 64, 64},
        '{1,  64,   4,  4, 4},
        '{3,   1,   5,  1, 4},
        '{0,   0,   9,  9, 9},
        '{7, 127, 100, 65, 3},
        '{3,   3,   7,  5, 2},
        '{2,  64,   1,  8, 8},
        '{4,   2,   3,  1, 2},
        '{5,  33,  17,  9, 2},
        '{4,   4,   4,  4, 4}
    };

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (cfg_ch.valid && cfg_ch.ready)
            sb.write_reg(cfg_ch.index, cfg_ch.data);
        if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.req_type, req_ch.site_index, req_ch.axis);
        if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.neighbor_index, rsp_ch.bad_request);
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(99, 0) >= stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_request(logic bkw, logic [pln_pkg::INDEX_BITS-1:0] site,
                                logic [pln_pkg::AXIS_BITS-1:0] ax);
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.req_type   = bkw;
        req_ch.site_index = site;
        req_ch.axis       = ax;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic stop_requests();
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic drain();
        stop_requests();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [pln_pkg::CFG_INDEX_BITS-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value[pln_pkg::CFG_DATA_BITS-1:0];
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic apply_lattice(int p);
        write_reg(pln_pkg::REG_DIM_COUNT, phase_tab[p][0]);
        write_reg(pln_pkg::REG_LEN_DIM0,  phase_tab[p][1]);
        write_reg(pln_pkg::REG_LEN_DIM1,  phase_tab[p][2]);
        write_reg(pln_pkg::REG_LEN_DIM2,  phase_tab[p][3]);
        write_reg(pln_pkg::REG_LEN_DIM3,  phase_tab[p][4]);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_random_item();
        longint unsigned lsize;
        longint unsigned site;
        longint unsigned stride;
        longint unsigned len;
        longint unsigned coord;
        longint unsigned index_max;
        int              dims_n;
        int              r;
        logic            bkw;
        logic [pln_pkg::AXIS_BITS-1:0] ax;
        index_max = (64'd1 << pln_pkg::INDEX_BITS) - 1;
        dims_n = sb.dims_in_use();
        lsize  = sb.site_total();
        bkw    = 1'($urandom_range(1, 0));
        ax     = pln_pkg::AXIS_BITS'($urandom_range(dims_n - 1, 0));
        site   = $urandom_range(int'(lsize), 1);
        r      = $urandom_range(99, 0);
        if (r < 30)
        begin
            // Move the site onto either end of the chosen axis to hit the wrap.
            stride = sb.axis_stride(ax);
            len    = sb.axis_len(ax);
            coord  = ((site - 1) % (stride * len)) / stride;
            site   = site - coord * stride;
            if ($urandom_range(1, 0))
                site = site + (len - 1) * stride;
        end
        else if (r < 40)
        begin
            case ($urandom_range(3, 0))
                0: site = 0;
                1: site = lsize + 1;
                2: site = index_max;
                default: site = $urandom() & index_max;
            endcase
        end
        else if (r < 48)
            ax = pln_pkg::AXIS_BITS'($urandom_range(3, 0));
        send_request(bkw, site[pln_pkg::INDEX_BITS-1:0], ax);
    endtask

    initial
    begin
        int p;
        int k;
        rst_n             = 1'b0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = 1'b0;
        req_ch.site_index = '0;
        req_ch.axis       = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = pln_pkg::REG_DIM_COUNT;
        cfg_ch.data       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset lattice is 4x4x4x4: first and last site along every axis.
        for (p = 0; p < 4; p++)
        begin
            for (k = 0; k < 2; k++)
            begin
                send_request(k[0], pln_pkg::INDEX_BITS'(1), p[pln_pkg::AXIS_BITS-1:0]);
                send_request(k[0], pln_pkg::INDEX_BITS'(256), p[pln_pkg::AXIS_BITS-1:0]);
            end
        end
        send_request(1'b0, pln_pkg::INDEX_BITS'(0), pln_pkg::AXIS_BITS'(0));
        send_request(1'b1, pln_pkg::INDEX_BITS'(257), pln_pkg::AXIS_BITS'(1));
        send_request(1'b0, {pln_pkg::INDEX_BITS{1'b1}}, pln_pkg::AXIS_BITS'(2));
        send_request(1'b1, pln_pkg::INDEX_BITS'(1) << (pln_pkg::INDEX_BITS - 1),
                     pln_pkg::AXIS_BITS'(3));
        send_request(1'b0, pln_pkg::INDEX_BITS'(22), pln_pkg::AXIS_BITS'(1));

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                apply_lattice(p);
            end
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 50; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Hold the sender until the pipeline has emptied once.
                if (p == 2 && k == ITEMS_PER_PHASE / 2)
                begin
                    stop_requests();
                    wait_for_results();
                end
                send_random_item();
            end
        end

        drain();
        if (sb.failures() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
